// File: rtl/tpm_pkg.sv
// Shared types, codes and helper functions of the triangle permutation matcher.
package tpm_pkg;

  localparam int MOLECULES_DEF = 1024;
  localparam int QUERIES_DEF   = 64;

  localparam logic [16:0] ERR_ONE = 17'd65536;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_CAND  = 2'd1,
    FN_READ  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MASK,
    ST_RUN,
    ST_FIN
  } state_t;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_TOL    = 2'd1;
  localparam logic [1:0] REG_INV    = 2'd2;

  typedef logic [1:0] vidx_t;

  // Vertex order of the six permutations.
  localparam vidx_t PERM [6][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
  };

  // Edge between two distinct vertices: ab, ac or bc.
  function automatic logic [1:0] edge_sel(input vidx_t x, input vidx_t y);
    logic [2:0] s;
    s = {1'b0, x} + {1'b0, y};
    case (s)
      3'd1:    edge_sel = 2'd0;
      3'd2:    edge_sel = 2'd1;
      default: edge_sel = 2'd2;
    endcase
  endfunction

  function automatic logic [15:0] adiff(input logic [15:0] a, input logic [15:0] b);
    adiff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [15:0] med3(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c);
    logic [15:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    m = (hi < c) ? hi : c;
    med3 = (lo > m) ? lo : m;
  endfunction

endpackage

// File: rtl/tpm_if.sv
// Request and response channel interfaces of the triangle permutation matcher.
interface tpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  query_slot;
  logic [9:0]  molecule;
  logic [7:0]  type_a;
  logic [7:0]  type_b;
  logic [7:0]  type_c;
  logic [15:0] dist_ab;
  logic [15:0] dist_ac;
  logic [15:0] dist_bc;

  modport source (output valid, func, query_slot, molecule, type_a, type_b, type_c,
                  dist_ab, dist_ac, dist_bc, input ready);
  modport sink (input valid, func, query_slot, molecule, type_a, type_b, type_c,
                dist_ab, dist_ac, dist_bc, output ready);
endinterface

interface tpm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] molecule_mask;
  logic        query_hit;
  logic [16:0] best_error_out;
  logic [63:0] candidate_hits;

  modport source (output valid, molecule_mask, query_hit, best_error_out, candidate_hits,
                  input ready);
  modport sink (input valid, molecule_mask, query_hit, best_error_out, candidate_hits,
                output ready);
endinterface

// File: rtl/triangle_permutation_matcher_core.sv
// Triangle permutation matcher: query store, candidate sequencer and result memories.
//
// Usage: words enter on req (valid/ready) and each gives exactly one word on rsp.
// func load writes a query slot, candidate compares the triangle against the first
// active_queries slots under all six vertex orders, read returns a molecule's mask
// and the stored error of one query, clear zeroes a molecule's mask.
// One item is worked at a time. Load and clear go from idle to the finish state, read
// passes a read state first; a candidate passes a mask read state and a run state, where
// the query memory delivers one slot per cycle into a compare, multiply and error
// read-modify-write pipe, then the mask is written back.
// The result sits in an output register; the next word is taken once the result of
// the previous one has moved there, even while the receiver stalls.
// After reset the mask memory is swept to zero; req.ready stays low during the sweep.
// Write registers over APB only while no word is in flight.
module triangle_permutation_matcher_core
  import tpm_pkg::*;
#(
  parameter int MOLECULES = MOLECULES_DEF,
  parameter int QUERIES   = QUERIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tpm_in_if.sink      req,
  tpm_out_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MW  = (MOLECULES > 1) ? $clog2(MOLECULES) : 1;
  localparam int QW  = (QUERIES > 1) ? $clog2(QUERIES) : 1;
  localparam int QCW = $clog2(QUERIES + 1);
  localparam int EDEPTH = MOLECULES * (2 ** QW);

  // Configuration registers
  logic [6:0]  active_queries;
  logic [15:0] tolerance;
  logic [24:0] inv_tolerance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_queries <= 7'd64;
      tolerance      <= 16'd256;
      inv_tolerance  <= 25'd65536;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ACTIVE: active_queries <= pwdata[6:0];
        REG_TOL:    tolerance      <= pwdata[15:0];
        REG_INV:    inv_tolerance  <= pwdata[24:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACTIVE: prdata = {25'd0, active_queries};
      REG_TOL:    prdata = {16'd0, tolerance};
      REG_INV:    prdata = {7'd0, inv_tolerance};
      default:    prdata = 32'd0;
    endcase
  end

  // Memories
  logic [23:0]        qtype_mem [QUERIES];
  logic [47:0]        qlen_mem [QUERIES];
  logic [QUERIES-1:0] mask_mem [MOLECULES];
  logic [16:0]        err_mem [EDEPTH];

  state_t state, state_next;

  logic accept;
  logic [MW-1:0] mol_idx;
  logic [QW-1:0] slot_idx;
  logic mol_ok, slot_ok;

  assign accept   = req.valid && req.ready;
  assign mol_idx  = MW'(req.molecule);
  assign slot_idx = QW'(req.query_slot);
  assign mol_ok   = 32'(req.molecule) < MOLECULES;
  assign slot_ok  = 32'(req.query_slot) < QUERIES;

  // Item registers
  logic [MW-1:0] mol_r;
  logic [QW-1:0] slot_r;
  logic          mol_ok_r, slot_ok_r;
  logic [7:0]    ct_r [3];
  logic [15:0]   cl_r [3];
  logic [QCW-1:0] n_r;
  logic [MW-1:0] mc;

  // Candidate pipe
  logic [QCW-1:0] qi;
  logic v1, v2, v3, v4;
  logic [QW-1:0] q1, q2, q3, q4;
  logic [71:0] qdata;
  logic [5:0]  tm2;
  logic [15:0] d2 [6][3];
  logic [15:0] best3;
  logic        found3, found4;
  logic [40:0] prod4;
  logic [QUERIES-1:0] mreg, hits;
  logic [QUERIES-1:0] mask_rdata;
  logic [16:0] err_rdata;

  logic issue, run_done;
  assign issue    = (state == ST_RUN) && (qi < n_r);
  assign run_done = (state == ST_RUN) && (qi >= n_r) && !v1 && !v2 && !v3 && !v4;

  // Result and output registers
  logic [QUERIES-1:0] res_mask, res_hits;
  logic        res_hit;
  logic [16:0] res_err;
  logic        out_valid;
  logic [63:0] out_mask, out_hits;
  logic        out_hit;
  logic [16:0] out_err;
  logic        out_free;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);

  assign rsp.valid          = out_valid;
  assign rsp.molecule_mask  = out_mask;
  assign rsp.query_hit      = out_hit;
  assign rsp.best_error_out = out_err;
  assign rsp.candidate_hits = out_hits;

  // Next state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (mc == MW'(MOLECULES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(req.func))
            FN_READ: state_next = ST_READ;
            FN_CAND: state_next = mol_ok ? ST_MASK : ST_FIN;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_READ: state_next = ST_FIN;
      ST_MASK: state_next = ST_RUN;
      ST_RUN:  if (run_done) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Mask memory port
  logic               mask_we;
  logic [MW-1:0]      mask_waddr;
  logic [QUERIES-1:0] mask_wdata;

  always_comb begin
    mask_we    = 1'b0;
    mask_waddr = mol_idx;
    mask_wdata = '0;
    if (state == ST_CLEAR) begin
      mask_we    = 1'b1;
      mask_waddr = mc;
    end else if (accept && func_t'(req.func) == FN_CLEAR && mol_ok) begin
      mask_we = 1'b1;
    end else if (run_done) begin
      mask_we    = 1'b1;
      mask_waddr = mol_r;
      mask_wdata = mreg | hits;
    end
  end

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_waddr] <= mask_wdata;
    mask_rdata <= mask_mem[mol_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) mc <= '0;
    else if (state == ST_CLEAR) mc <= mc + MW'(1);
  end

  // Query memory
  always_ff @(posedge clk) begin
    if (accept && func_t'(req.func) == FN_LOAD && slot_ok) begin
      qtype_mem[slot_idx] <= {req.type_c, req.type_b, req.type_a};
      qlen_mem[slot_idx]  <= {req.dist_bc, req.dist_ac, req.dist_ab};
    end
    qdata <= {qlen_mem[qi[QW-1:0]], qtype_mem[qi[QW-1:0]]};
  end

  // Stage 1: type match and edge differences per permutation
  logic [5:0]  tm1;
  logic [15:0] d1 [6][3];

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      tm1[p] = (qdata[7:0] == ct_r[PERM[p][0]]) && (qdata[15:8] == ct_r[PERM[p][1]])
               && (qdata[23:16] == ct_r[PERM[p][2]]);
      d1[p][0] = adiff(qdata[39:24], cl_r[edge_sel(PERM[p][0], PERM[p][1])]);
      d1[p][1] = adiff(qdata[55:40], cl_r[edge_sel(PERM[p][0], PERM[p][2])]);
      d1[p][2] = adiff(qdata[71:56], cl_r[edge_sel(PERM[p][1], PERM[p][2])]);
    end
  end

  // Stage 2: tolerance, median and least median over permutations
  logic [15:0] best2;
  logic        found2;

  always_comb begin
    logic        ok;
    logic [15:0] m;
    best2  = '0;
    found2 = 1'b0;
    for (int p = 0; p < 6; p++) begin
      ok = tm2[p] && d2[p][0] <= tolerance && d2[p][1] <= tolerance
           && d2[p][2] <= tolerance;
      m = med3(d2[p][0], d2[p][1], d2[p][2]);
      if (ok && (!found2 || m < best2)) begin
        best2  = m;
        found2 = 1'b1;
      end
    end
  end

  // Stage 4: saturate and min-update the stored error
  logic [32:0] sh4;
  logic [16:0] err4, err_new;

  assign sh4     = prod4[40:8];
  assign err4    = (sh4 > 33'(ERR_ONE)) ? ERR_ONE : sh4[16:0];
  assign err_new = (mreg[q4] && err_rdata < err4) ? err_rdata : err4;

  logic [MW+QW-1:0] err_raddr;
  assign err_raddr = (state == ST_IDLE) ? {mol_idx, slot_idx} : {mol_r, q3};

  always_ff @(posedge clk) begin
    if (v4 && found4) err_mem[{mol_r, q4}] <= err_new;
    err_rdata <= err_mem[err_raddr];
  end

  // Pipe valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    q1     <= qi[QW-1:0];
    q2     <= q1;
    q3     <= q2;
    q4     <= q3;
    tm2    <= tm1;
    d2     <= d1;
    best3  <= best2;
    found3 <= found2;
    found4 <= found3;
    prod4  <= 41'(best3) * 41'(inv_tolerance);
  end

  // Item latch, sequencer and results
  always_ff @(posedge clk) begin
    if (accept) begin
      mol_r     <= mol_idx;
      slot_r    <= slot_idx;
      mol_ok_r  <= mol_ok;
      slot_ok_r <= slot_ok;
      ct_r[0]   <= req.type_a;
      ct_r[1]   <= req.type_b;
      ct_r[2]   <= req.type_c;
      cl_r[0]   <= req.dist_ab;
      cl_r[1]   <= req.dist_ac;
      cl_r[2]   <= req.dist_bc;
      n_r       <= (32'(active_queries) > QUERIES) ? QCW'(QUERIES) : QCW'(active_queries);
      res_mask  <= '0;
      res_hit   <= 1'b0;
      res_err   <= '0;
      res_hits  <= '0;
    end
    if (state == ST_READ && mol_ok_r) begin
      res_mask <= mask_rdata;
      if (slot_ok_r && mask_rdata[slot_r]) begin
        res_hit <= 1'b1;
        res_err <= err_rdata;
      end
    end
    if (state == ST_MASK) begin
      mreg <= mask_rdata;
      hits <= '0;
      qi   <= '0;
    end
    if (issue) qi <= qi + QCW'(1);
    if (v4 && found4) hits[q4] <= 1'b1;
    if (run_done) res_hits <= hits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_mask <= 64'(res_mask);
      out_hit  <= res_hit;
      out_err  <= res_err;
      out_hits <= 64'(res_hits);
    end
  end

  // Checks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !req.ready)
    else $error("word accepted during mask sweep");

  a_pipe_empty_outside_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(v1 || v2 || v3 || v4))
    else $error("compare pipe busy while idle");

  a_err_saturated: assert property (@(posedge clk) disable iff (rst)
    (v4 && found4) |-> (err_new <= ERR_ONE))
    else $error("stored error above one");

  a_mask_write_at_end: assert property (@(posedge clk) disable iff (rst)
    run_done |=> (state == ST_FIN))
    else $error("candidate did not finish after mask write");

endmodule

// File: tb/sv/tb_triangle_permutation_matcher_core.sv
// Self-checking testbench for triangle_permutation_matcher_core.
`timescale 1ns / 100ps

module tb_triangle_permutation_matcher_core;
  import tpm_pkg::*;

  localparam int NQ = 64;
  localparam int NM = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 120;
  localparam int ORD [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};

  typedef struct {
    func_t       fn;
    logic [5:0]  slot;
    logic [9:0]  mol;
    logic [7:0]  ty [3];
    logic [15:0] len [3];
  } word_t;

  typedef struct {
    logic [63:0] mask;
    logic        hit;
    logic [16:0] err;
    logic [63:0] hits;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tpm_in_if req ();
  tpm_out_if rsp ();

  triangle_permutation_matcher_core u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [6:0]  act_q = 7'd64;
  logic [15:0] tol = 16'd256;
  logic [24:0] inv_tol = 25'd65536;
  logic [7:0]  q_ty [NQ][3];
  logic [15:0] q_len [NQ][3];
  logic [63:0] mol_masks [NM];
  logic [16:0] err_store [NM*NQ];

  // generator shadow of the query store
  logic [7:0]  g_ty [NQ][3];
  logic [15:0] g_len [NQ][3];

  word_t   pending_words [$];
  answer_t expected_answers [$];
  word_t   cur;
  int      mismatches = 0;
  int      cycles = 0;
  int      stall_left = 0;
  bit      stall_request = 0, stall_done = 0, no_idle = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int m = 0; m < NM; m++) mol_masks[m] = '0;
    req.valid = 1'b0;
    req.func = FN_LOAD; req.query_slot = '0; req.molecule = '0;
    req.type_a = '0; req.type_b = '0; req.type_c = '0;
    req.dist_ab = '0; req.dist_ac = '0; req.dist_bc = '0;
    rsp.ready = 1'b0;
  end

  function automatic int edge_of(int x, int y);
    return x + y - 1;
  endfunction

  function automatic answer_t match_word(word_t w);
    answer_t a;
    int n;
    a = '{default: '0};
    case (w.fn)
      FN_LOAD: begin
        q_ty[w.slot] = w.ty;
        q_len[w.slot] = w.len;
      end
      FN_CAND: begin
        n = (act_q > NQ) ? NQ : int'(act_q);
        for (int q = 0; q < n; q++) begin
          bit found;
          logic [15:0] best, d [3], lo, hi, md;
          logic [63:0] prod;
          logic [16:0] e;
          found = 0;
          best = '0;
          for (int p = 0; p < 6; p++) begin
            if (q_ty[q][0] == w.ty[ORD[p][0]] && q_ty[q][1] == w.ty[ORD[p][1]] &&
                q_ty[q][2] == w.ty[ORD[p][2]]) begin
              for (int k = 0; k < 3; k++) begin
                logic [15:0] c;
                c = w.len[edge_of(ORD[p][k == 2 ? 1 : 0], ORD[p][k == 0 ? 1 : 2])];
                d[k] = (q_len[q][k] > c) ? q_len[q][k] - c : c - q_len[q][k];
              end
              if (d[0] <= tol && d[1] <= tol && d[2] <= tol) begin
                lo = (d[0] < d[1]) ? d[0] : d[1];
                hi = (d[0] < d[1]) ? d[1] : d[0];
                md = (d[2] < lo) ? lo : ((d[2] > hi) ? hi : d[2]);
                if (!found || md < best) best = md;
                found = 1;
              end
            end
          end
          if (found) begin
            prod = ({48'd0, best} * {39'd0, inv_tol}) >> 8;
            e = (prod > 64'd65536) ? 17'd65536 : prod[16:0];
            if (!mol_masks[w.mol][q] || e < err_store[w.mol*NQ + q])
              err_store[w.mol*NQ + q] = e;
            mol_masks[w.mol][q] = 1'b1;
            a.hits[q] = 1'b1;
          end
        end
      end
      FN_READ: begin
        a.mask = mol_masks[w.mol];
        if (a.mask[w.slot]) begin
          a.hit = 1'b1;
          a.err = err_store[w.mol*NQ + w.slot];
        end
      end
      default: mol_masks[w.mol] = '0;
    endcase
    return a;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) expected_answers.push_back(match_word(cur));
      if (req.valid && !req.ready) begin
        req.valid <= 1'b1;
      end else if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 24)) begin
        cur = pending_words.pop_front();
        req.func <= cur.fn;
        req.query_slot <= cur.slot;
        req.molecule <= cur.mol;
        req.type_a <= cur.ty[0];
        req.type_b <= cur.ty[1];
        req.type_c <= cur.ty[2];
        req.dist_ab <= cur.len[0];
        req.dist_ac <= cur.len[1];
        req.dist_bc <= cur.len[2];
        req.valid <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response ready, with one long hold-off once a word is waiting
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_request && !stall_done && rsp.valid) begin
      stall_done <= 1;
      stall_left <= 400;
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // response monitor
  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_answers.size() == 0) begin
        report("unexpected word", rsp.candidate_hits, '0);
      end else begin
        want = expected_answers.pop_front();
        if (rsp.molecule_mask !== want.mask) report("molecule_mask", rsp.molecule_mask, want.mask);
        if (rsp.query_hit !== want.hit)
          report("query_hit", 64'(rsp.query_hit), 64'(want.hit));
        if (rsp.best_error_out !== want.err)
          report("best_error_out", 64'(rsp.best_error_out), 64'(want.err));
        if (rsp.candidate_hits !== want.hits)
          report("candidate_hits", rsp.candidate_hits, want.hits);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE: act_q = val[6:0];
      REG_TOL:    tol = val[15:0];
      default:    inv_tol = val[24:0];
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || req.valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic word_t blank(func_t fn, int slot, int mol);
    word_t w;
    w.fn = fn; w.slot = 6'(slot); w.mol = 10'(mol);
    for (int k = 0; k < 3; k++) begin
      w.ty[k] = 8'($urandom); w.len[k] = 16'($urandom);
    end
    return w;
  endfunction

  task automatic push_load(int slot, bit wide);
    word_t w;
    w = blank(FN_LOAD, slot, $urandom_range(NM - 1));
    if (!wide) for (int k = 0; k < 3; k++) w.ty[k] = 8'($urandom_range(3));
    g_ty[slot] = w.ty;
    g_len[slot] = w.len;
    pending_words.push_back(w);
  endtask

  // candidate built from a stored query in a random vertex order, edges jittered
  task automatic push_near(int q, int mol, int spread);
    word_t w;
    int p, v;
    w = blank(FN_CAND, $urandom_range(NQ - 1), mol);
    p = $urandom_range(5);
    for (int k = 0; k < 3; k++) w.ty[ORD[p][k]] = g_ty[q][k];
    for (int k = 0; k < 3; k++) begin
      v = int'(g_len[q][k]) + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      w.len[edge_of(ORD[p][k == 2 ? 1 : 0], ORD[p][k == 0 ? 1 : 2])] = 16'(v);
    end
    pending_words.push_back(w);
  endtask

  task automatic run_phase(int count);
    int r, mol, spread;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      mol = ($urandom_range(9) == 0) ? $urandom_range(NM - 1) : $urandom_range(15);
      spread = ($urandom_range(3) == 0) ? $urandom_range(65535) : int'(tol);
      if (r < 8) push_load($urandom_range(NQ - 1), $urandom_range(7) == 0);
      else if (r < 55) push_near($urandom_range(NQ - 1), mol, spread);
      else if (r < 62) pending_words.push_back(blank(FN_CAND, $urandom_range(NQ - 1), mol));
      else if (r < 94) pending_words.push_back(blank(FN_READ, $urandom_range(NQ - 1), mol));
      else pending_words.push_back(blank(FN_CLEAR, $urandom_range(NQ - 1), mol));
    end
  endtask

  task automatic set_regs(int a, int t, int i);
    drain();
    reg_write(REG_ACTIVE, a);
    reg_write(REG_TOL, t);
    reg_write(REG_INV, i);
  endtask

  initial begin
    word_t w;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int s = 0; s < NQ; s++) push_load(s, s >= 60);

    // exact copy, reads hit and missing, boundary edges, clear
    push_near(0, 0, 0);
    pending_words.push_back(blank(FN_READ, 0, 0));
    pending_words.push_back(blank(FN_READ, 63, 0));
    pending_words.push_back(blank(FN_READ, 5, NM - 1));
    push_near(1, NM - 1, int'(tol));
    push_near(63, NM - 1, 1);
    pending_words.push_back(blank(FN_READ, 1, NM - 1));
    pending_words.push_back(blank(FN_READ, 63, NM - 1));
    w = blank(FN_CAND, 0, 2);
    w.ty = '{8'hff, 8'hff, 8'hff}; w.len = '{16'h0, 16'hffff, 16'h0};
    pending_words.push_back(w);
    w.ty = '{8'h00, 8'h00, 8'h00}; w.len = '{16'hffff, 16'h0, 16'hffff};
    pending_words.push_back(w);
    push_near(0, 0, 2 * int'(tol));
    pending_words.push_back(blank(FN_READ, 0, 0));
    pending_words.push_back(blank(FN_CLEAR, 0, 0));
    pending_words.push_back(blank(FN_READ, 0, 0));
    push_near(0, 0, 2);
    pending_words.push_back(blank(FN_READ, 0, 0));
    pending_words.push_back(blank(FN_CLEAR, 0, NM - 1));
    pending_words.push_back(blank(FN_READ, 63, NM - 1));

    run_phase(180);
    @(posedge clk);
    stall_request <= 1;
    run_phase(20);

    set_regs(1, 1, 16777216);
    run_phase(170);
    set_regs(64, 65535, 256);
    no_idle <= 1;
    run_phase(170);
    set_regs(37, 4000, 4194);
    no_idle <= 0;
    run_phase(170);
    set_regs(20, 300, 1);
    run_phase(170);
    set_regs(64, 512, 16777216);
    run_phase(170);

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tpm_pkg.sv
rtl/tpm_if.sv
rtl/triangle_permutation_matcher_core.sv
tb/sv/tb_triangle_permutation_matcher_core.sv
